[rtl/wbps_pkg.sv]
// wbps_pkg: shared types and constants for the wildcard byte pattern search.
// Used by wbps_cell and wildcard_byte_pattern_search; depends on nothing.
`timescale 1ns / 1ps

package wbps_pkg;

    // Fixed field widths
    localparam int BYTE_W     = 8;
    localparam int PAT_BYTES  = 16;
    localparam int LEN_W      = 5;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_OFS_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WILDCARD     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH       = 2'd3;

    typedef logic [BYTE_W-1:0]                 byte_t;
    typedef logic [PAT_BYTES-1:0][BYTE_W-1:0]  pat_bytes_t;

    // Pattern setup as seen by every cell; len is already clamped
    typedef struct packed {
        pat_bytes_t           bytes;
        logic [PAT_BYTES-1:0] wild;
        logic [LEN_W-1:0]     len;
    } pat_cfg_t;

endpackage

[rtl/wildcard_byte_pattern_search.sv]
// wildcard_byte_pattern_search: top level, config registers, cell chain, result register.
// Depends on wbps_pkg and wbps_cell.
`timescale 1ns / 1ps

// Takes one byte of a region per cycle and reports, on the byte marked last,
// whether a pattern of up to 16 bytes (each optionally a wildcard) occurred
// and the offset of the leftmost match. The recent bytes sit in a chain of
// cells, each comparing its byte against the pattern byte it lines up with,
// so a full window is checked every cycle: one transfer per clock, and the
// result appears in the output register the cycle after the last byte is
// taken. A new byte is taken while a result waits, unless that result is
// stalled and nothing frees the register. Offsets saturate at 2^OFFSET_BITS-1.
// Write configuration only between transfers of the search; the block does not check it.
module wildcard_byte_pattern_search #(
    parameter int MAX_PATTERN = 16,
    parameter int OFFSET_BITS = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_write,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Byte stream
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [wbps_pkg::BYTE_W-1:0]           data_byte,
    input  logic                                  last_byte,
    // Result
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic [wbps_pkg::OUT_OFS_W-1:0]        match_offset
);

    localparam int CAP   = (MAX_PATTERN < wbps_pkg::PAT_BYTES) ? MAX_PATTERN
                                                                : wbps_pkg::PAT_BYTES;
    localparam int NCELL = (CAP > 1) ? CAP - 1 : 1;
    localparam logic [wbps_pkg::LEN_W-1:0] CAP_LEN = wbps_pkg::LEN_W'(CAP);

    // Configuration registers
    logic [63:0]                          pat_low_reg;
    logic [63:0]                          pat_high_reg;
    logic [wbps_pkg::PAT_BYTES-1:0]       wild_reg;
    logic [wbps_pkg::LEN_W-1:0]           len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            wild_reg     <= '0;
            len_reg      <= wbps_pkg::LEN_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                wbps_pkg::CFG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                wbps_pkg::CFG_WILDCARD:     wild_reg     <= cfg_data[wbps_pkg::PAT_BYTES-1:0];
                wbps_pkg::CFG_LENGTH:       len_reg      <= cfg_data[wbps_pkg::LEN_W-1:0];
                default:                    len_reg      <= len_reg;
            endcase
        end
    end

    // Clamped length and the pattern view shared by all cells
    logic [wbps_pkg::LEN_W-1:0] eff_len;
    wbps_pkg::pat_cfg_t         cfg;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = wbps_pkg::LEN_W'(1);
        end
        else if (len_reg > CAP_LEN)
        begin
            eff_len = CAP_LEN;
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign cfg.bytes = {pat_high_reg, pat_low_reg};
    assign cfg.wild  = wild_reg;
    assign cfg.len   = eff_len;

    // Handshake
    logic accept;
    assign in_stall = out_valid & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Cell chain: cell 0 holds the previous byte
    wbps_pkg::byte_t chain [NCELL+1];
    logic [NCELL-1:0] cell_hit;

    assign chain[0] = data_byte;

    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        wbps_cell #(
            .IDX (k)
        ) u_cell (
            .clk      (clk),
            .shift    (accept),
            .byte_in  (chain[k]),
            .cfg      (cfg),
            .byte_out (chain[k+1]),
            .hit      (cell_hit[k])
        );
    end

    // Current byte against the last pattern byte in use
    logic [wbps_pkg::LEN_W-1:0] last_idx_full;
    logic [3:0]                 last_idx;
    logic                       cur_hit;

    assign last_idx_full = eff_len - wbps_pkg::LEN_W'(1);
    assign last_idx      = last_idx_full[3:0];
    assign cur_hit       = cfg.wild[last_idx] | (data_byte == cfg.bytes[last_idx]);

    // Region state
    logic [OFFSET_BITS-1:0] pos_reg,   pos_next;
    logic                   seen_reg,  seen_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;

    logic [OFFSET_BITS-1:0] len_m1;
    logic                   window_full;
    logic                   match_now;

    assign len_m1      = OFFSET_BITS'(last_idx_full);
    assign window_full = (pos_reg >= len_m1);
    assign match_now   = ~seen_reg & window_full & cur_hit & (&cell_hit);

    // Result register
    logic                           out_valid_reg, out_valid_next;
    logic                           found_reg,     found_next;
    logic [wbps_pkg::OUT_OFS_W-1:0] ofs_reg,       ofs_next;
    logic [63:0]                    start_ext;
    logic                           seen_upd;
    logic [OFFSET_BITS-1:0]         start_upd;

    always_comb
    begin
        seen_upd  = seen_reg | match_now;
        start_upd = match_now ? (pos_reg - len_m1) : start_reg;
        start_ext = 64'(start_upd);

        pos_next       = pos_reg;
        seen_next      = seen_reg;
        start_next     = start_reg;
        out_valid_next = out_valid_reg & out_stall;
        found_next     = found_reg;
        ofs_next       = ofs_reg;

        if (accept)
        begin
            if (last_byte)
            begin
                pos_next       = '0;
                seen_next      = 1'b0;
                start_next     = '0;
                out_valid_next = 1'b1;
                found_next     = seen_upd;
                ofs_next       = seen_upd ? start_ext[wbps_pkg::OUT_OFS_W-1:0] : '0;
            end
            else
            begin
                seen_next  = seen_upd;
                start_next = start_upd;
                // saturating byte offset
                if (~&pos_reg)
                begin
                    pos_next = pos_reg + OFFSET_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            seen_reg      <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            seen_reg      <= seen_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        ofs_reg   <= ofs_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = ofs_reg;

endmodule

[rtl/wbps_cell.sv]
// wbps_cell: one stage of the byte history chain with its own comparator.
// Depends on wbps_pkg.
`timescale 1ns / 1ps

module wbps_cell #(
    parameter int IDX = 0
) (
    input  logic                clk,
    input  logic                shift,
    input  wbps_pkg::byte_t     byte_in,
    input  wbps_pkg::pat_cfg_t  cfg,
    output wbps_pkg::byte_t     byte_out,
    output logic                hit
);

    // Distance of this cell behind the current byte is IDX+1
    localparam logic [wbps_pkg::LEN_W-1:0] BACK_PLUS_ONE = wbps_pkg::LEN_W'(IDX + 2);

    wbps_pkg::byte_t              byte_reg;
    logic [wbps_pkg::LEN_W-1:0]   pidx_full;
    logic [3:0]                   pidx;
    logic                         active;

    // Held byte moves one place down the chain per transfer
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out = byte_reg;

    // Pattern byte lined up with this cell: len-2-IDX
    assign active    = (cfg.len >= BACK_PLUS_ONE);
    assign pidx_full = cfg.len - BACK_PLUS_ONE;
    assign pidx      = pidx_full[3:0];

    always_comb
    begin
        if (!active)
        begin
            hit = 1'b1;
        end
        else
        begin
            hit = cfg.wild[pidx] | (byte_reg == cfg.bytes[pidx]);
        end
    end

endmodule

[sim/tb.sv]
// tb: self-checking bench for wildcard_byte_pattern_search; streams byte regions through
// the valid/stall channels and checks every found/offset result against a local match tracker.
// Depends on wbps_pkg and the RTL of wildcard_byte_pattern_search.
`timescale 1ns / 1ps

module tb;

    localparam int OFS_W           = 32;
    localparam int HISTORY_DEPTH   = wbps_pkg::PAT_BYTES - 1;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int SETTLE_CYCLES   = 4;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic             found;
        logic [OFS_W-1:0] offset;
    } match_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // Tracks one region at a time and queues the found/offset pair due on its last byte
    class match_tracker;
        logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low;
        logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high;
        logic [wbps_pkg::PAT_BYTES-1:0]  wild;
        logic [wbps_pkg::LEN_W-1:0]      length_reg;
        wbps_pkg::byte_t                 history [HISTORY_DEPTH];
        logic [OFS_W-1:0]                position;
        logic                            seen;
        logic [OFS_W-1:0]                first_start;
        match_t                          expected_matches [$];
        int                              errors;

        function new();
            pattern_low  = '0;
            pattern_high = '0;
            wild         = '0;
            length_reg   = wbps_pkg::LEN_W'(1);
            errors       = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (history[i])
                history[i] = '0;
            position    = '0;
            seen        = 1'b0;
            first_start = '0;
        endfunction

        function void set_reg(logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                              logic [wbps_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                wbps_pkg::CFG_PATTERN_LOW:  pattern_low  = val;
                wbps_pkg::CFG_PATTERN_HIGH: pattern_high = val;
                wbps_pkg::CFG_WILDCARD:     wild         = val[wbps_pkg::PAT_BYTES-1:0];
                wbps_pkg::CFG_LENGTH:       length_reg   = val[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function wbps_pkg::byte_t pattern_byte(int unsigned i);
            if (i < 8)
                return pattern_low[8 * i +: 8];
            return pattern_high[8 * (i - 8) +: 8];
        endfunction

        // Zero length acts as one, anything past the pattern store is clamped
        function int unsigned pattern_span();
            int unsigned n;
            n = 32'(length_reg);
            if (n == 0)
                n = 1;
            if (n > wbps_pkg::PAT_BYTES)
                n = wbps_pkg::PAT_BYTES;
            return n;
        endfunction

        function void take_byte(wbps_pkg::byte_t cur, logic last);
            int unsigned     n;
            int unsigned     back;
            bit              hit;
            wbps_pkg::byte_t b;
            match_t          m;
            n = pattern_span();
            // compare the window ending at this byte once it is full
            if (!seen && position >= OFS_W'(n - 1))
            begin
                hit = 1'b1;
                for (int unsigned i = 0; i < n; i++)
                begin
                    back = n - 1 - i;
                    b    = (back == 0) ? cur : history[back - 1];
                    if (!wild[i] && b != pattern_byte(i))
                        hit = 1'b0;
                end
                if (hit)
                begin
                    seen        = 1'b1;
                    first_start = position - OFS_W'(n - 1);
                end
            end
            if (last)
            begin
                m.found  = seen;
                m.offset = seen ? first_start : '0;
                expected_matches.push_back(m);
                clear_region();
            end
            else
            begin
                for (int i = HISTORY_DEPTH - 1; i > 0; i--)
                    history[i] = history[i - 1];
                history[0] = cur;
                // offset saturates
                if (position != '1)
                    position++;
            end
        endfunction

        function void check_match(logic f, logic [OFS_W-1:0] ofs);
            match_t m;
            if (expected_matches.size() == 0)
            begin
                $error("unexpected result: found %0d match_offset 0x%0h", f, ofs);
                errors++;
                return;
            end
            m = expected_matches.pop_front();
            if (f !== m.found)
            begin
                $error("found: expected %0d, got %0d", m.found, f);
                errors++;
            end
            if (ofs !== m.offset)
            begin
                $error("match_offset: expected 0x%0h, got 0x%0h", m.offset, ofs);
                errors++;
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_write = 1'b0;
    logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    wbps_pkg::byte_t                 data_byte = '0;
    logic                            last_byte = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            found;
    logic [OFS_W-1:0]                match_offset;

    match_tracker    tracker = new();
    wbps_pkg::byte_t region_q [$];
    int unsigned     burst_left = 0;
    stall_mode_t     stall_mode = STALL_NONE;
    int unsigned     mode_left = 0;
    int unsigned     quiet_cycles = 0;

    wildcard_byte_pattern_search u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .match_offset (match_offset)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Monitor: results first, since they always belong to earlier bytes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_match(found, match_offset);
            if (in_valid && !in_stall)
                tracker.take_byte(data_byte, last_byte);
        end
    end

    // Receiver stall: switches between stall styles every so often
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(3));
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
            default:     out_stall <= mode_left[2];
        endcase
    end

    // Watchdog on cycles with no transfer and no register write
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wbps_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        tracker.set_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic program_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [15:0] mask, input logic [4:0] len);
        write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(wbps_pkg::CFG_WILDCARD, wbps_pkg::CFG_DATA_W'(mask));
        write_reg(wbps_pkg::CFG_LENGTH, wbps_pkg::CFG_DATA_W'(len));
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One byte transfer; the sender sometimes pauses between bursts of random length
    task automatic send_byte(input wbps_pkg::byte_t d, input logic l);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic send_region();
        foreach (region_q[i])
            send_byte(region_q[i], i == region_q.size() - 1);
    endtask

    // Let every queued result come out before the pattern changes
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_matches.size() != 0 || out_valid)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random region, with copies of the pattern planted and sometimes spoiled
    task automatic make_region();
        int unsigned n;
        int unsigned rlen;
        int unsigned at;
        int unsigned k;
        int unsigned plants;
        n = tracker.pattern_span();
        case ($urandom_range(9))
            0:       rlen = $urandom_range(1, 3);
            1:       rlen = $urandom_range(60, 120);
            default: rlen = $urandom_range(1, 2 * n + 12);
        endcase
        region_q.delete();
        for (int unsigned j = 0; j < rlen; j++)
            region_q.push_back($urandom_range(1) ? wbps_pkg::byte_t'($urandom_range(255))
                                                 : tracker.pattern_byte($urandom_range(n - 1)));
        plants = (rlen >= n) ? $urandom_range(2) : 0;
        for (int unsigned j = 0; j < plants; j++)
        begin
            at = $urandom_range(rlen - n);
            for (k = 0; k < n; k++)
                if (!tracker.wild[k])
                    region_q[at + k] = tracker.pattern_byte(k);
            // near miss: flip one bit of a fixed byte
            if ($urandom_range(3) == 0)
            begin
                k = $urandom_range(n - 1);
                if (!tracker.wild[k])
                    region_q[at + k] ^= wbps_pkg::byte_t'(1 << $urandom_range(7));
            end
        end
    endtask

    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] mask;
        logic [4:0]  len;
        int unsigned sent;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pattern: one zero byte; single-byte regions
        region_q = '{8'h00};
        send_region();
        region_q = '{8'hFF};
        send_region();
        drain();

        // 12 ?? 34
        program_pattern(64'h0000_0000_0034_0012, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0002, 5'd3);
        region_q = '{8'h12};                       // shorter than the pattern
        send_region();
        region_q = '{8'h12, 8'h55, 8'h34};         // match at the very start
        send_region();
        region_q = '{8'h00, 8'hFF, 8'h12, 8'h99, 8'h34, 8'h12, 8'h00, 8'h34};
        send_region();                             // second match must not win
        region_q = '{8'h12, 8'h34};
        send_region();
        region_q = '{8'hFF, 8'h12, 8'h00, 8'h35, 8'h12, 8'hFF, 8'h34};
        send_region();                             // near miss then a match
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            lo   = {$urandom, $urandom};
            hi   = {$urandom, $urandom};
            mask = 16'($urandom & $urandom);
            len  = 5'($urandom_range(1, 16));
            case (ph)
                0:
                begin
                    len  = 5'd16;
                    mask = '0;
                end
                1: len = 5'd1;
                2: len = 5'd0;
                3: len = 5'd31;
                4: len = 5'd17;
                5: mask = '1;
                6:
                begin
                    lo  = '1;
                    hi  = '1;
                    len = 5'd16;
                end
                7:
                begin
                    lo = '0;
                    hi = '0;
                end
                default: ;
            endcase
            program_pattern(lo, hi, mask, len);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                make_region();
                sent += region_q.size();
                send_region();
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
